[design/rssf_pkg.sv]
// Shared types, constants and the per-channel 3x3 kernel function for the
// RGB 3x3 smooth/sharpen filter. No dependencies.
package rssf_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int DIM_W     = 12;
    localparam int PIX_W     = 24;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [DIM_W-1:0] MIN_DIM       = DIM_W'(3);
    localparam logic [DIM_W-1:0] MAX_DIM       = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] WIDTH_RESET   = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET  = DIM_W'(480);

    // Register index as seen in paddr[3:2]
    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    typedef enum logic {
        MODE_SMOOTH  = 1'b0,
        MODE_SHARPEN = 1'b1
    } t_mode;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Beat held between the input register and the result register
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             done;
        logic [COL_W-1:0] col;
        t_rgb             px;
    } t_stage;

    // p[row*3 + col], row 0 on top, col 0 on the left
    function automatic logic [7:0] conv_channel(input t_mode mode,
                                                input logic [8:0][7:0] p);
        logic [9:0]         corners;
        logic [9:0]         sides;
        logic [11:0]        gsum;
        logic [10:0]        ring;
        logic [11:0]        center9;
        logic signed [12:0] diff;
        logic [12:0]        mag;
        logic [7:0]         res;
        corners = 10'(p[0]) + 10'(p[2]) + 10'(p[6]) + 10'(p[8]);
        sides   = 10'(p[1]) + 10'(p[3]) + 10'(p[5]) + 10'(p[7]);
        gsum    = {2'b00, corners} + {1'b0, sides, 1'b0} + {2'b00, p[4], 2'b00};
        ring    = {1'b0, corners} + {1'b0, sides};
        center9 = {1'b0, p[4], 3'b000} + {4'b0000, p[4]};
        diff    = signed'({1'b0, center9}) - signed'({2'b00, ring});
        // negative sums give their magnitude
        mag     = diff[12] ? 13'(-diff) : 13'(diff);
        if (mode == MODE_SMOOTH) begin
            res = gsum[11:4];
        end else if (mag > 13'd255) begin
            res = 8'hFF;
        end else begin
            res = mag[7:0];
        end
        return res;
    endfunction

endpackage

[design/rssf_pix_if.sv]
// Input pixel channel: valid/ready handshake with one RGB pixel per beat.
// No dependencies.
interface rssf_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

[design/rssf_res_if.sv]
// Result channel: valid/ready handshake with one filtered pixel per beat.
// No dependencies.
interface rssf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_done;

    modport source (output valid, out_red, out_green, out_blue, frame_done,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_done,
                    output ready);
endinterface

[design/rssf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered, enable-held read data. No dependencies.
module rssf_ram #(
    parameter int  WIDTH = 24,
    parameter int  DEPTH = 2048,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/rssf_filter.sv]
// 3x3 window registers, convolution of the three channels and the result
// register. Depends on rssf_pkg and rssf_res_if.
module rssf_filter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rssf_pkg::t_stage i_s1,
    input  rssf_pkg::t_rgb   i_upper,
    input  rssf_pkg::t_rgb   i_middle,
    input  rssf_pkg::t_mode  i_mode,
    output logic             o_advance,
    rssf_res_if.source       o_res
);
    import rssf_pkg::*;

    // r_win[0..2]: column two back, r_win[3..5]: column one back (top..bottom)
    t_rgb r_win [6];
    t_rgb col   [3];
    t_rgb r_out;
    logic r_out_valid;
    logic r_out_done;
    logic out_free;
    t_rgb n_out;

    logic [8:0][7:0] win_r;
    logic [8:0][7:0] win_g;
    logic [8:0][7:0] win_b;

    assign col[0] = i_upper;
    assign col[1] = i_middle;
    assign col[2] = i_s1.px;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_r[i*3 + 0] = r_win[i].red;
            win_r[i*3 + 1] = r_win[3 + i].red;
            win_r[i*3 + 2] = col[i].red;
            win_g[i*3 + 0] = r_win[i].green;
            win_g[i*3 + 1] = r_win[3 + i].green;
            win_g[i*3 + 2] = col[i].green;
            win_b[i*3 + 0] = r_win[i].blue;
            win_b[i*3 + 1] = r_win[3 + i].blue;
            win_b[i*3 + 2] = col[i].blue;
        end
        n_out.red   = conv_channel(i_mode, win_r);
        n_out.green = conv_channel(i_mode, win_g);
        n_out.blue  = conv_channel(i_mode, win_b);
    end

    assign out_free  = !r_out_valid || o_res.ready;
    // beats that produce no result never wait on the output side
    assign o_advance = i_s1.valid && (!i_s1.emit || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (o_advance) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i]     <= r_win[3 + i];
                r_win[3 + i] <= col[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance && i_s1.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_s1.emit) begin
            r_out      <= n_out;
            r_out_done <= i_s1.done;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.out_red    = r_out.red;
    assign o_res.out_green  = r_out.green;
    assign o_res.out_blue   = r_out.blue;
    assign o_res.frame_done = r_out_done;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("result dropped or changed while stalled");

endmodule

[design/rgb_3x3_smooth_sharpen_filter_top.sv]
// Top level of the RGB 3x3 smooth/sharpen filter: APB registers, raster
// counters, two line-store RAMs and the input register stage.
// Depends on rssf_pkg, rssf_pix_if, rssf_res_if, rssf_ram and rssf_filter.
//
//  channel   dir   handshake                payload
//  i_pix     in    valid/ready              in_red, in_green, in_blue
//  o_res     out   valid/ready              out_red, out_green, out_blue, frame_done
//  apb       in    psel/penable/pwrite      paddr, pwdata, prdata (pready tied high)
//
// One pixel per clock unless o_res stalls; results leave from the result register.
// The line-store read is issued at the input beat, so its registered data meets
// the pixel in the input register stage; convolution sits before the result register.
// Synchronous active-low reset clears counters, window and handshake state;
// line stores are not cleared. A stalled result register holds the input stage
// only for a pixel in row 2 or below and column 2 or beyond; others keep flowing.
module rgb_3x3_smooth_sharpen_filter_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rssf_pix_if.sink                     i_pix,
    rssf_res_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rssf_pkg::ADDR_W-1:0]  paddr,
    input  logic [rssf_pkg::DATA_W-1:0]  pwdata,
    output logic [rssf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import rssf_pkg::*;

    t_mode            r_mode;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [COL_W-1:0] r_col;
    logic [DIM_W-1:0] r_row;
    t_stage           r_s1;
    t_stage           n_s1;

    t_reg_idx         reg_idx;
    logic             cfg_wr;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic             col_last;
    logic             row_last;
    logic             in_accept;
    logic             s1_adv;
    t_rgb             px_in;
    t_rgb             upper_rd;
    t_rgb             middle_rd;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SMOOTH;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MODE:   r_mode   <= t_mode'(pwdata[0]);
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:   prdata = DATA_W'(r_mode);
            REG_WIDTH:  prdata = DATA_W'(r_width);
            REG_HEIGHT: prdata = DATA_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    // ---------------- raster counters ----------------
    always_comb begin
        if (r_width < MIN_DIM) begin
            w_eff = MIN_DIM;
        end else if (r_width > MAX_DIM) begin
            w_eff = MAX_DIM;
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height < MIN_DIM) ? MIN_DIM : r_height;
    end

    assign col_last  = (DIM_W'(r_col) + DIM_W'(1)) >= w_eff;
    assign row_last  = ({1'b0, r_row} + 13'd1) >= {1'b0, h_eff};
    assign in_accept = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + DIM_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // ---------------- input register stage ----------------
    assign i_pix.ready = !r_s1.valid || s1_adv;
    assign px_in       = '{red: i_pix.in_red, green: i_pix.in_green, blue: i_pix.in_blue};

    always_comb begin
        n_s1 = r_s1;
        if (in_accept) begin
            n_s1.valid = 1'b1;
            n_s1.emit  = (r_row >= DIM_W'(2)) && (r_col >= COL_W'(2));
            n_s1.done  = (r_row == h_eff - DIM_W'(1))
                      && (DIM_W'(r_col) == w_eff - DIM_W'(1));
            n_s1.col   = r_col;
            n_s1.px    = px_in;
        end else if (s1_adv) begin
            n_s1.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
        end
        r_s1.emit <= n_s1.emit;
        r_s1.done <= n_s1.done;
        r_s1.col  <= n_s1.col;
        r_s1.px   <= n_s1.px;
    end

    // ---------------- line stores ----------------
    // read at the input beat, write back when the beat leaves the stage
    rssf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1.col),
        .i_wdata (middle_rd),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (upper_rd)
    );

    rssf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1.col),
        .i_wdata (r_s1.px),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (middle_rd)
    );

    rssf_filter u_filter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (r_s1),
        .i_upper   (upper_rd),
        .i_middle  (middle_rd),
        .i_mode    (r_mode),
        .o_advance (s1_adv),
        .o_res     (o_res)
    );

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && s1_adv) |-> (r_s1.col != r_col))
        else $error("line store read and write hit the same column");

    a_beat_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1.valid)
        else $error("accepted pixel missing from input stage");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && !s1_adv) |=> (r_s1.valid && $stable(r_s1.col)
                                     && $stable(r_s1.px)))
        else $error("input stage lost a stalled beat");

endmodule
